// ===== hdl/fwdd_pkg.sv =====
package fwdd_pkg;

   // Field widths of the command and result channels
   localparam int CMD_W       = 3;
   localparam int VALUE_W     = 32;
   localparam int CAP_W       = 6;
   localparam int FILL_W      = 6;

   // Queue sizing
   localparam int DEPTH_DEFAULT = 32;
   localparam int MAX_RESULTS   = 32;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd5;

   // Register indexes (word address bits)
   localparam logic [1:0] REG_PUSH_ALLOWED = 2'd0;
   localparam logic [1:0] REG_POP_ALLOWED  = 2'd1;
   localparam logic [1:0] REG_MIN_FILL     = 2'd2;

endpackage

// ===== hdl/fifo_with_delete_and_drain.sv =====
// Push, flush, count query and refused commands answer from the dispatch state; pop reads the
// head entry and answers from the pop-out state; delete reads and compares each entry in turn,
// then moves each later entry one slot toward the head; no new command is taken while busy.
// Drain alternates read and output states, one item per entry, paced by the registered memory read.
// Reset (synchronous, active high) empties the queue and restores the enable registers;
// entry storage is not cleared. The receiver cannot stall: each item shows for one cycle.
module fifo_with_delete_and_drain #(
   parameter int DEPTH = fwdd_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [fwdd_pkg::CMD_W-1:0]        req_command,
   input  logic [fwdd_pkg::VALUE_W-1:0]      req_item_value,
   input  logic [fwdd_pkg::CAP_W-1:0]        req_drain_capacity,
   // result channel
   output logic                              rsp_strobe,
   output logic [fwdd_pkg::VALUE_W-1:0]      rsp_out_value,
   output logic                              rsp_ok,
   output logic                              rsp_found,
   output logic [fwdd_pkg::FILL_W-1:0]       rsp_fill_level,
   output logic                              rsp_last,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fwdd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fwdd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fwdd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > fwdd_pkg::CAP_W) ? CW : fwdd_pkg::CAP_W;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_EXEC      = 9'b000000010,
      ST_POP_OUT   = 9'b000000100,
      ST_SCAN_RD   = 9'b000001000,
      ST_SCAN_CMP  = 9'b000010000,
      ST_SHIFT_RD  = 9'b000100000,
      ST_SHIFT_WR  = 9'b001000000,
      ST_DRAIN_RD  = 9'b010000000,
      ST_DRAIN_OUT = 9'b100000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [fwdd_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [fwdd_pkg::VALUE_W-1:0]      val_ff, val_in;
   logic [fwdd_pkg::CAP_W-1:0]        cap_ff, cap_in;
   logic [IW-1:0]                     head_ff, head_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic                              push_allowed_ff, push_allowed_in;
   logic                              pop_allowed_ff, pop_allowed_in;
   logic [fwdd_pkg::CAP_W-1:0]        min_fill_ff, min_fill_in;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [fwdd_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [fwdd_pkg::FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [fwdd_pkg::VALUE_W-1:0]      mem [DEPTH];
   logic [fwdd_pkg::VALUE_W-1:0]      rd_data_ff;
   logic [IW-1:0]                     rd_addr;
   logic                              wr_en;
   logic [fwdd_pkg::VALUE_W-1:0]      wr_data;

   logic [CW-1:0]                     slot_off;
   logic [CW:0]                       slot_sum;
   logic [IW-1:0]                     slot;
   logic [CW-1:0]                     idx_inc;
   logic [CW-1:0]                     count_inc;
   logic [CW-1:0]                     count_dec;
   logic                              accept;
   logic                              cfg_wr;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign idx_inc   = idx_ff + CW'(1);
   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);

   // Pick the ring offset for the shared slot adder
   always_comb begin
      unique case (state_ff)
         ST_SHIFT_RD, ST_POP_OUT:  slot_off = idx_inc;
         ST_EXEC, ST_DRAIN_OUT:    slot_off = count_ff;
         default:                  slot_off = idx_ff;
      endcase
   end

   // Shared slot unit: head plus offset, wrapped once around the ring
   always_comb begin
      slot_sum = (CW+1)'(head_ff) + (CW+1)'(slot_off);
      if (slot_sum >= (CW+1)'(DEPTH)) begin
         slot_sum = slot_sum - (CW+1)'(DEPTH);
      end
      slot = IW'(slot_sum);
   end

   // Read the head directly on dispatch, else the computed slot
   assign rd_addr = (state_ff == ST_EXEC) ? head_ff : slot;

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      cap_in        = cap_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      wr_data       = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_ok_in     = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_fill_in   = fwdd_pkg::FILL_W'(count_ff);
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            // latch the command
            if (accept) begin
               cmd_in   = req_command;
               val_in   = req_item_value;
               cap_in   = req_drain_capacity;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            idx_in   = '0;
            state_in = ST_IDLE;
            unique case (cmd_ff)
               fwdd_pkg::CMD_PUSH: begin
                  rsp_strobe_in = 1'b1;
                  if (push_allowed_ff && (count_ff < CW'(DEPTH))) begin
                     wr_en       = 1'b1;
                     count_in    = count_inc;
                     rsp_ok_in   = 1'b1;
                     rsp_fill_in = fwdd_pkg::FILL_W'(count_inc);
                  end
               end
               fwdd_pkg::CMD_POP: begin
                  if (!pop_allowed_ff || (XW'(count_ff) <= XW'(min_fill_ff))
                      || (count_ff == '0)) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = ST_POP_OUT;
                  end
               end
               fwdd_pkg::CMD_DELETE: begin
                  if (!pop_allowed_ff) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
               fwdd_pkg::CMD_FLUSH: begin
                  count_in      = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
                  rsp_fill_in   = '0;
               end
               fwdd_pkg::CMD_DRAIN: begin
                  if ((XW'(cap_ff) < XW'(count_ff))
                      || (XW'(count_ff) > XW'(fwdd_pkg::MAX_RESULTS))) begin
                     rsp_strobe_in = 1'b1;
                  end else if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_ok_in     = 1'b1;
                     rsp_fill_in   = '0;
                  end else begin
                     state_in = ST_DRAIN_RD;
                  end
               end
               fwdd_pkg::CMD_COUNT: begin
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         ST_POP_OUT: begin
            // hand out the head entry and advance
            head_in       = slot;
            count_in      = count_dec;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_ok_in     = 1'b1;
            rsp_fill_in   = fwdd_pkg::FILL_W'(count_dec);
            state_in      = ST_IDLE;
         end
         ST_SCAN_RD: begin
            if (idx_ff < count_ff) begin
               state_in = ST_SCAN_CMP;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_ok_in     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN_CMP: begin
            if (rd_data_ff == val_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            // fetch the next entry, or close the gap and report
            if (idx_inc < count_ff) begin
               state_in = ST_SHIFT_WR;
            end else begin
               count_in      = count_dec;
               rsp_strobe_in = 1'b1;
               rsp_ok_in     = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_fill_in   = fwdd_pkg::FILL_W'(count_dec);
               state_in      = ST_IDLE;
            end
         end
         ST_SHIFT_WR: begin
            // move the entry one slot toward the head
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_inc;
            state_in = ST_SHIFT_RD;
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_ok_in     = 1'b1;
            rsp_fill_in   = '0;
            rsp_last_in   = (idx_inc == count_ff);
            if (idx_inc == count_ff) begin
               head_in  = slot;
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_DRAIN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register port decode
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      push_allowed_in = push_allowed_ff;
      pop_allowed_in  = pop_allowed_ff;
      min_fill_in     = min_fill_ff;
      if (cfg_wr) begin
         unique case (paddr[3:2])
            fwdd_pkg::REG_PUSH_ALLOWED: push_allowed_in = pwdata[0];
            fwdd_pkg::REG_POP_ALLOWED:  pop_allowed_in  = pwdata[0];
            fwdd_pkg::REG_MIN_FILL:     min_fill_in     = pwdata[fwdd_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         fwdd_pkg::REG_PUSH_ALLOWED: prdata = fwdd_pkg::CSR_DATA_W'(push_allowed_ff);
         fwdd_pkg::REG_POP_ALLOWED:  prdata = fwdd_pkg::CSR_DATA_W'(pop_allowed_ff);
         fwdd_pkg::REG_MIN_FILL:     prdata = fwdd_pkg::CSR_DATA_W'(min_fill_ff);
         default:                    prdata = '0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         head_ff         <= '0;
         count_ff        <= '0;
         push_allowed_ff <= 1'b1;
         pop_allowed_ff  <= 1'b1;
         min_fill_ff     <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         push_allowed_ff <= push_allowed_in;
         pop_allowed_ff  <= pop_allowed_in;
         min_fill_ff     <= min_fill_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      cap_ff       <= cap_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_last       = rsp_last_ff;

   // Checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the block busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("final item shown while still busy");

   a_strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("item shown without work in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_ok && (cmd_ff == fwdd_pkg::CMD_PUSH)
      |-> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("successful push did not grow the queue by one");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int DEPTH         = fwdd_pkg::DEPTH_DEFAULT;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 34;
   localparam int PLAN_LEN      = 21;

   // Codes the block does not know
   localparam logic [fwdd_pkg::CMD_W-1:0] CMD_BAD_LO = 3'd6;
   localparam logic [fwdd_pkg::CMD_W-1:0] CMD_BAD_HI = 3'd7;

   localparam logic [fwdd_pkg::CSR_ADDR_W-1:0] ADDR_PUSH_ALLOWED =
      {fwdd_pkg::REG_PUSH_ALLOWED, 2'b00};
   localparam logic [fwdd_pkg::CSR_ADDR_W-1:0] ADDR_POP_ALLOWED  =
      {fwdd_pkg::REG_POP_ALLOWED, 2'b00};
   localparam logic [fwdd_pkg::CSR_ADDR_W-1:0] ADDR_MIN_FILL     =
      {fwdd_pkg::REG_MIN_FILL, 2'b00};

   localparam logic TYPED = 1'b1;
   localparam logic PRED  = 1'b0;

   typedef struct packed {
      logic [fwdd_pkg::VALUE_W-1:0] out_value;
      logic                         ok;
      logic                         found;
      logic [fwdd_pkg::FILL_W-1:0]  fill_level;
      logic                         last;
   } rsp_type;

   typedef struct packed {
      logic [fwdd_pkg::CMD_W-1:0]   cmd;
      logic [fwdd_pkg::VALUE_W-1:0] value;
      logic [fwdd_pkg::CAP_W-1:0]   cap;
      logic                         typed;
      rsp_type                      want;
   } step_type;

   // Directed items; typed rows carry the result that replaces the prediction
   step_type plan [PLAN_LEN] = '{
      '{fwdd_pkg::CMD_COUNT,  32'h0000_0000, 6'd0,  TYPED, {32'h0, 1'b1, 1'b0, 6'd0, 1'b1}},
      '{fwdd_pkg::CMD_POP,    32'h0000_0000, 6'd0,  TYPED, {32'h0, 1'b0, 1'b0, 6'd0, 1'b1}},
      '{fwdd_pkg::CMD_DELETE, 32'h0000_0005, 6'd0,  TYPED, {32'h0, 1'b1, 1'b0, 6'd0, 1'b1}},
      '{fwdd_pkg::CMD_DRAIN,  32'h0000_0000, 6'd0,  TYPED, {32'h0, 1'b1, 1'b0, 6'd0, 1'b1}},
      '{fwdd_pkg::CMD_PUSH,   32'hFFFF_FFFF, 6'd0,  TYPED, {32'h0, 1'b1, 1'b0, 6'd1, 1'b1}},
      '{fwdd_pkg::CMD_PUSH,   32'h0000_0000, 6'd32, TYPED, {32'h0, 1'b1, 1'b0, 6'd2, 1'b1}},
      '{fwdd_pkg::CMD_PUSH,   32'hA5A5_5A5A, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_PUSH,   32'h0000_0000, 6'd0,  PRED,  41'd0},
      '{CMD_BAD_LO,           32'hFFFF_FFFF, 6'd32, TYPED, {32'h0, 1'b0, 1'b0, 6'd4, 1'b1}},
      '{CMD_BAD_HI,           32'h0000_0000, 6'd0,  TYPED, {32'h0, 1'b0, 1'b0, 6'd4, 1'b1}},
      '{fwdd_pkg::CMD_DELETE, 32'h0000_0000, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_DRAIN,  32'h0000_0000, 6'd2,  TYPED, {32'h0, 1'b0, 1'b0, 6'd3, 1'b1}},
      '{fwdd_pkg::CMD_POP,    32'h0000_0000, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_DELETE, 32'h1234_5678, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_PUSH,   32'h0000_0001, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_PUSH,   32'h0000_0002, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_DRAIN,  32'h0000_0000, 6'd32, PRED,  41'd0},
      '{fwdd_pkg::CMD_COUNT,  32'hFFFF_FFFF, 6'd31, TYPED, {32'h0, 1'b1, 1'b0, 6'd0, 1'b1}},
      '{fwdd_pkg::CMD_PUSH,   32'h0000_0007, 6'd0,  PRED,  41'd0},
      '{fwdd_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0,  TYPED, {32'h0, 1'b1, 1'b0, 6'd0, 1'b1}},
      '{fwdd_pkg::CMD_DELETE, 32'hFFFF_FFFF, 6'd0,  PRED,  41'd0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [fwdd_pkg::CMD_W-1:0]      req_command = '0;
   logic [fwdd_pkg::VALUE_W-1:0]    req_item_value = '0;
   logic [fwdd_pkg::CAP_W-1:0]      req_drain_capacity = '0;
   logic                            rsp_strobe;
   logic [fwdd_pkg::VALUE_W-1:0]    rsp_out_value;
   logic                            rsp_ok;
   logic                            rsp_found;
   logic [fwdd_pkg::FILL_W-1:0]     rsp_fill_level;
   logic                            rsp_last;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [fwdd_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [fwdd_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [fwdd_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // Shadow of the queue and its registers
   logic [fwdd_pkg::VALUE_W-1:0] held [$];
   logic                         push_en = 1'b1;
   logic                         pop_en = 1'b1;
   logic [fwdd_pkg::FILL_W-1:0]  min_level = '0;

   rsp_type pending_rsp [$];
   rsp_type got_rsp;
   rsp_type want_rsp;

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int settings_used = 0;
   int peak_fill = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;

   fifo_with_delete_and_drain dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Work out the results of one accepted item and advance the shadow queue
   task automatic model_command(input logic [fwdd_pkg::CMD_W-1:0] cmd,
                                input logic [fwdd_pkg::VALUE_W-1:0] val,
                                input logic [fwdd_pkg::CAP_W-1:0] cap);
      rsp_type r;
      int      n;
      int      hit;
      int      i;
      n = held.size();
      hit = -1;
      r = {32'h0, 1'b0, 1'b0, 6'(n), 1'b1};
      case (cmd)
         fwdd_pkg::CMD_PUSH: begin
            if (push_en && n < DEPTH) begin
               held.push_back(val);
               r.ok = 1'b1;
               r.fill_level = 6'(n + 1);
            end
         end
         fwdd_pkg::CMD_POP: begin
            if (pop_en && n > int'(min_level) && n > 0) begin
               r.out_value = held.pop_front();
               r.ok = 1'b1;
               r.fill_level = 6'(n - 1);
            end
         end
         fwdd_pkg::CMD_DELETE: begin
            if (pop_en) begin
               r.ok = 1'b1;
               for (i = 0; i < n; i++) begin
                  if (hit < 0 && held[i] == val) hit = i;
               end
               if (hit >= 0) begin
                  held.delete(hit);
                  r.found = 1'b1;
                  r.fill_level = 6'(n - 1);
               end
            end
         end
         fwdd_pkg::CMD_FLUSH: begin
            held.delete();
            r.ok = 1'b1;
            r.fill_level = '0;
         end
         fwdd_pkg::CMD_DRAIN: begin
            // Hand out every entry in order; only the final one is marked last
            if (int'(cap) >= n && n <= fwdd_pkg::MAX_RESULTS) begin
               r.ok = 1'b1;
               r.fill_level = '0;
               for (i = 0; i < n - 1; i++) begin
                  pending_rsp.push_back({held[i], 1'b1, 1'b0, 6'd0, 1'b0});
               end
               if (n > 0) r.out_value = held[n-1];
               held.delete();
            end
         end
         fwdd_pkg::CMD_COUNT: begin
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      pending_rsp.push_back(r);
      if (held.size() > peak_fill) peak_fill = held.size();
   endtask

   // Offer one item, idling first at the current rate; return at the edge that takes it
   task automatic send_item(input logic [fwdd_pkg::CMD_W-1:0] cmd,
                            input logic [fwdd_pkg::VALUE_W-1:0] val,
                            input logic [fwdd_pkg::CAP_W-1:0] cap);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_command <= fwdd_pkg::CMD_W'($urandom);
         req_item_value <= $urandom;
         req_drain_capacity <= fwdd_pkg::CAP_W'($urandom);
         @(negedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_item_value <= val;
      req_drain_capacity <= cap;
      do @(posedge clock); while (busy);
      model_command(cmd, val, cap);
      items_sent++;
   endtask

   // Hold the sender until every expected result is back and the block is quiet
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready
   task automatic csr_access(input logic wr, input logic [fwdd_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [fwdd_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [fwdd_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Write all three registers, read them back, and update the shadow copy
   task automatic apply_config(input logic p_en, input logic q_en,
                               input logic [fwdd_pkg::FILL_W-1:0] lvl);
      logic [fwdd_pkg::CSR_DATA_W-1:0] setting [3];
      logic [fwdd_pkg::CSR_DATA_W-1:0] mask [3];
      logic [fwdd_pkg::CSR_ADDR_W-1:0] addr [3];
      logic [fwdd_pkg::CSR_DATA_W-1:0] rd;
      int                              k;
      setting[0] = fwdd_pkg::CSR_DATA_W'(p_en);
      setting[1] = fwdd_pkg::CSR_DATA_W'(q_en);
      setting[2] = fwdd_pkg::CSR_DATA_W'(lvl);
      mask[0] = 32'h1;
      mask[1] = 32'h1;
      mask[2] = 32'h3F;
      addr[0] = ADDR_PUSH_ALLOWED;
      addr[1] = ADDR_POP_ALLOWED;
      addr[2] = ADDR_MIN_FILL;
      for (k = 0; k < 3; k++) csr_access(1'b1, addr[k], setting[k], rd);
      for (k = 0; k < 3; k++) begin
         csr_access(1'b0, addr[k], '0, rd);
         if ((rd & mask[k]) !== setting[k]) begin
            errors++;
            $display("%0t: register at %h reads back: expected %h, actual %h",
                     $time, addr[k], setting[k], rd & mask[k]);
         end
      end
      push_en = p_en;
      pop_en = q_en;
      min_level = lvl;
      settings_used++;
   endtask

   // Random items under one register setting, mostly valid commands on live handles
   task automatic run_phase(input logic p_en, input logic q_en,
                            input logic [fwdd_pkg::FILL_W-1:0] lvl,
                            input int gap_pct, input bit hold_mid);
      logic [fwdd_pkg::CMD_W-1:0]   cmd;
      logic [fwdd_pkg::VALUE_W-1:0] val;
      logic [fwdd_pkg::CAP_W-1:0]   cap;
      int                           r;
      int                           k;
      settle();
      apply_config(p_en, q_en, lvl);
      idle_pct = gap_pct;
      for (k = 0; k < PHASE_ITEMS; k++) begin
         if (hold_mid && k == PHASE_ITEMS / 2) settle();
         r = $urandom_range(99);
         val = $urandom;
         cap = fwdd_pkg::CAP_W'($urandom_range(0, DEPTH));
         if (r < 40) begin
            cmd = fwdd_pkg::CMD_PUSH;
            if ($urandom_range(9) < 3) val = $urandom_range(7);
         end else if (r < 60) begin
            cmd = fwdd_pkg::CMD_POP;
         end else if (r < 75) begin
            cmd = fwdd_pkg::CMD_DELETE;
            if (held.size() > 0 && $urandom_range(3) != 0)
               val = held[$urandom_range(held.size() - 1)];
            else if ($urandom_range(1))
               val = $urandom_range(7);
         end else if (r < 79) begin
            cmd = fwdd_pkg::CMD_FLUSH;
         end else if (r < 88) begin
            cmd = fwdd_pkg::CMD_DRAIN;
            if ($urandom_range(3) != 0)
               cap = fwdd_pkg::CAP_W'($urandom_range(held.size(), DEPTH));
         end else if (r < 97) begin
            cmd = fwdd_pkg::CMD_COUNT;
         end else begin
            cmd = $urandom_range(1) ? CMD_BAD_HI : CMD_BAD_LO;
         end
         send_item(cmd, val, cap);
      end
   endtask

   // Check each result item against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_rsp = {rsp_out_value, rsp_ok, rsp_found, rsp_fill_level, rsp_last};
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value=%h ok=%b found=%b fill=%0d last=%b",
                     $time, got_rsp.out_value, got_rsp.ok, got_rsp.found,
                     got_rsp.fill_level, got_rsp.last);
         end else begin
            want_rsp = pending_rsp.pop_front();
            results_checked++;
            if (got_rsp !== want_rsp) begin
               errors++;
               $display("%0t: result mismatch: expected value=%h ok=%b found=%b fill=%0d last=%b",
                        $time, want_rsp.out_value, want_rsp.ok, want_rsp.found,
                        want_rsp.fill_level, want_rsp.last);
               $display("%0t:                  actual value=%h ok=%b found=%b fill=%0d last=%b",
                        $time, got_rsp.out_value, got_rsp.ok, got_rsp.found,
                        got_rsp.fill_level, got_rsp.last);
            end
         end
      end
   end

   // Count cycles in which no item moves on either channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int k;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      apply_config(1'b1, 1'b1, 6'd0);
      idle_pct = 0;

      // Walk the directed table
      for (k = 0; k < PLAN_LEN; k++) begin
         send_item(plan[k].cmd, plan[k].value, plan[k].cap);
         if (plan[k].typed) begin
            void'(pending_rsp.pop_back());
            pending_rsp.push_back(plan[k].want);
         end
      end

      // Fill to the brim, overflow once, then drain the full queue
      for (k = 0; k <= DEPTH; k++)
         send_item(fwdd_pkg::CMD_PUSH, $urandom, fwdd_pkg::CAP_W'($urandom_range(0, DEPTH)));
      send_item(fwdd_pkg::CMD_DRAIN, $urandom, fwdd_pkg::CAP_W'(DEPTH - 1));
      send_item(fwdd_pkg::CMD_DELETE, held[DEPTH-1], '0);
      send_item(fwdd_pkg::CMD_PUSH, $urandom, '0);
      send_item(fwdd_pkg::CMD_DRAIN, $urandom, fwdd_pkg::CAP_W'(DEPTH));

      run_phase(1'b1, 1'b1, 6'd0,  0,  1'b1);
      run_phase(1'b1, 1'b1, 6'd3,  71, 1'b0);
      run_phase(1'b0, 1'b1, 6'd0,  32, 1'b0);
      run_phase(1'b1, 1'b0, 6'd32, 0,  1'b0);
      run_phase(1'b1, 1'b1, 6'd31, 71, 1'b0);
      run_phase(1'b0, 1'b0, 6'd17, 32, 1'b0);
      run_phase(1'b1, 1'b1, 6'd0,  32, 1'b0);
      settle();

      $display("Sent %0d commands under %0d register settings; %0d result items checked.",
               items_sent, settings_used, results_checked);
      $display("Queue held up to %0d handles; %0d errors seen.", peak_fill, errors);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== fifo_with_delete_and_drain.f =====
hdl/fwdd_pkg.sv
hdl/fifo_with_delete_and_drain.sv
sim/testbench.sv
